// ===== rtl/core/ecpr_pkg.sv =====
`timescale 1ns / 1ps

package ecpr_pkg;

   localparam int PAGE_W = 20;

   // action codes
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_ACCESS = 2'd1;
   localparam logic [1:0] ACT_VICTIM = 2'd2;

   // result status codes
   localparam logic [2:0] STATUS_DONE         = 3'd0;
   localparam logic [2:0] STATUS_VICTIM       = 3'd1;
   localparam logic [2:0] STATUS_EMPTY        = 3'd2;
   localparam logic [2:0] STATUS_FULL         = 3'd3;
   localparam logic [2:0] STATUS_NOT_RESIDENT = 3'd4;

   typedef struct packed {
      logic [1:0]        action;
      logic [PAGE_W-1:0] page_number;
      logic              is_write;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [PAGE_W-1:0] victim_page;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACC,
      S_ACC_END,
      S_SCAN,
      S_VIC,
      S_SH_RD,
      S_SH_WR,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;            // capture request, clear index and hit flag
      logic       insert;          // append page at the tail
      logic       acc_rd;          // read slot at index for compare, advance index
      logic       scan_step;       // age bits at index, advance index with wrap
      logic       vic_rd;          // read slot at index (victim)
      logic       vic_take;        // capture victim, close the gap in the bits
      logic       sh_rd;           // read slot at index + 1
      logic       sh_wr;           // write read data at index, advance index
      logic       status_set;      // load status code, clear victim page
      logic       status_from_hit; // status picked from the access hit flag
      logic [2:0] status_code;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic empty;
      logic full;
      logic idx_last;   // index is the last resident slot
      logic page_clear; // both bits of the slot at index are clear
   } sts_type;

endpackage

// ===== rtl/core/ecpr_ram.sv =====
`timescale 1ns / 1ps

module ecpr_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/core/ecpr_ctrl.sv =====
`timescale 1ns / 1ps

module ecpr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_action,
   input  ecpr_pkg::sts_type sts,
   output ecpr_pkg::cmd_type cmd,
   output logic             busy,
   output logic             rsp_strobe
);

   ecpr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecpr_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ecpr_pkg::S_IDLE: begin
            if (start) begin
               unique case (req_action)
                  ecpr_pkg::ACT_ACCESS: begin
                     state_in = sts.empty ? ecpr_pkg::S_RESP : ecpr_pkg::S_ACC;
                  end
                  ecpr_pkg::ACT_VICTIM: begin
                     state_in = sts.empty ? ecpr_pkg::S_RESP : ecpr_pkg::S_SCAN;
                  end
                  default: begin
                     state_in = ecpr_pkg::S_RESP;
                  end
               endcase
            end
         end
         ecpr_pkg::S_ACC: begin
            if (sts.idx_last) begin
               state_in = ecpr_pkg::S_ACC_END;
            end
         end
         ecpr_pkg::S_ACC_END: state_in = ecpr_pkg::S_RESP;
         ecpr_pkg::S_SCAN: begin
            if (sts.page_clear) begin
               state_in = ecpr_pkg::S_VIC;
            end
         end
         ecpr_pkg::S_VIC: begin
            state_in = sts.idx_last ? ecpr_pkg::S_RESP : ecpr_pkg::S_SH_RD;
         end
         ecpr_pkg::S_SH_RD: state_in = ecpr_pkg::S_SH_WR;
         ecpr_pkg::S_SH_WR: begin
            state_in = sts.idx_last ? ecpr_pkg::S_RESP : ecpr_pkg::S_SH_RD;
         end
         ecpr_pkg::S_RESP: state_in = ecpr_pkg::S_IDLE;
         default: state_in = ecpr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.status_code = ecpr_pkg::STATUS_DONE;
      busy = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ecpr_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               unique case (req_action)
                  ecpr_pkg::ACT_INSERT: begin
                     cmd.status_set = 1'b1;
                     if (sts.full) begin
                        cmd.status_code = ecpr_pkg::STATUS_FULL;
                     end else begin
                        cmd.insert = 1'b1;
                     end
                  end
                  ecpr_pkg::ACT_ACCESS: begin
                     // non-empty case resolves at the end of the compare sweep
                     cmd.status_set = sts.empty;
                     cmd.status_code = ecpr_pkg::STATUS_NOT_RESIDENT;
                  end
                  ecpr_pkg::ACT_VICTIM: begin
                     cmd.status_set = sts.empty;
                     cmd.status_code = ecpr_pkg::STATUS_EMPTY;
                  end
                  default: begin
                     cmd.status_set = 1'b1;
                  end
               endcase
            end
         end
         ecpr_pkg::S_ACC: cmd.acc_rd = 1'b1;
         ecpr_pkg::S_ACC_END: begin
            cmd.status_set = 1'b1;
            cmd.status_from_hit = 1'b1;
         end
         ecpr_pkg::S_SCAN: begin
            if (sts.page_clear) begin
               cmd.vic_rd = 1'b1;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ecpr_pkg::S_VIC:   cmd.vic_take = 1'b1;
         ecpr_pkg::S_SH_RD: cmd.sh_rd = 1'b1;
         ecpr_pkg::S_SH_WR: cmd.sh_wr = 1'b1;
         ecpr_pkg::S_RESP:  rsp_strobe = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== rtl/core/ecpr_dp.sv =====
`timescale 1ns / 1ps

module ecpr_dp #(
   parameter int FRAMES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  ecpr_pkg::req_type req_data,
   input  ecpr_pkg::cmd_type cmd,
   output ecpr_pkg::sts_type sts,
   output ecpr_pkg::rsp_type rsp_data
);

   localparam int IDXW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNTW = $clog2(FRAMES + 1);

   logic [ecpr_pkg::PAGE_W-1:0] page_ff;
   logic                        is_write_ff;
   logic [CNTW-1:0]             count_ff, count_in;
   logic [IDXW-1:0]             idx_ff, idx_in;
   logic [IDXW-1:0]             cmp_idx_ff;
   logic                        cmp_vld_ff;
   logic                        hit_ff, hit_in;
   logic [FRAMES-1:0]           acc_ff, acc_in;
   logic [FRAMES-1:0]           dirty_ff, dirty_in;
   logic [2:0]                  status_ff;
   logic [ecpr_pkg::PAGE_W-1:0] victim_ff;

   logic                        ram_wr_en;
   logic [IDXW-1:0]             ram_wr_addr;
   logic [ecpr_pkg::PAGE_W-1:0] ram_wr_data;
   logic                        ram_rd_en;
   logic [IDXW-1:0]             ram_rd_addr;
   logic [ecpr_pkg::PAGE_W-1:0] ram_q;
   logic                        match;
   logic                        idx_last;

   ecpr_ram #(
      .WIDTH(ecpr_pkg::PAGE_W),
      .DEPTH(FRAMES)
   ) u_slots (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_q)
   );

   assign idx_last = ((CNTW'(idx_ff) + CNTW'(1)) == count_ff);
   assign match    = cmp_vld_ff && (ram_q == page_ff);

   always_comb begin
      ram_wr_en   = cmd.insert | cmd.sh_wr;
      ram_wr_addr = cmd.insert ? count_ff[IDXW-1:0] : idx_ff;
      ram_wr_data = cmd.insert ? req_data.page_number : ram_q;
      ram_rd_en   = cmd.acc_rd | cmd.vic_rd | cmd.sh_rd;
      ram_rd_addr = cmd.sh_rd ? (idx_ff + IDXW'(1)) : idx_ff;
   end

   always_comb begin
      sts.empty      = (count_ff == '0);
      sts.full       = (count_ff == CNTW'(FRAMES));
      sts.idx_last   = idx_last;
      sts.page_clear = !acc_ff[idx_ff] && !dirty_ff[idx_ff];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNTW'(1);
      end else if (cmd.vic_take) begin
         count_in = count_ff - CNTW'(1);
      end

      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.scan_step && idx_last) begin
         idx_in = '0;   // wrap to the oldest page for the next pass
      end else if (cmd.acc_rd || cmd.scan_step || cmd.sh_wr) begin
         idx_in = idx_ff + IDXW'(1);
      end

      hit_in = cmd.load ? 1'b0 : (hit_ff | match);
   end

   always_comb begin
      acc_in   = acc_ff;
      dirty_in = dirty_ff;
      for (int j = 0; j < FRAMES; j++) begin
         if (cmd.insert && (count_ff[IDXW-1:0] == IDXW'(j))) begin
            acc_in[j]   = 1'b0;
            dirty_in[j] = 1'b0;
         end
         if (match && (cmp_idx_ff == IDXW'(j))) begin
            acc_in[j] = 1'b1;
            if (is_write_ff) begin
               dirty_in[j] = 1'b1;
            end
         end
         if (cmd.scan_step && (idx_ff == IDXW'(j))) begin
            // one bit set: both cleared; both set: dirty survives
            acc_in[j]   = 1'b0;
            dirty_in[j] = acc_ff[j] & dirty_ff[j];
         end
         if (cmd.vic_take && (j >= int'(idx_ff))) begin
            if (j < FRAMES - 1) begin
               acc_in[j]   = acc_ff[j+1];
               dirty_in[j] = dirty_ff[j+1];
            end else begin
               acc_in[j]   = 1'b0;
               dirty_in[j] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         acc_ff     <= '0;
         dirty_ff   <= '0;
         status_ff  <= ecpr_pkg::STATUS_DONE;
         victim_ff  <= '0;
      end else begin
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         cmp_vld_ff <= cmd.acc_rd;
         hit_ff     <= hit_in;
         acc_ff     <= acc_in;
         dirty_ff   <= dirty_in;
         if (cmd.vic_take) begin
            status_ff <= ecpr_pkg::STATUS_VICTIM;
            victim_ff <= ram_q;
         end else if (cmd.status_set) begin
            victim_ff <= '0;
            if (cmd.status_from_hit) begin
               status_ff <= (hit_ff | match) ? ecpr_pkg::STATUS_DONE
                                             : ecpr_pkg::STATUS_NOT_RESIDENT;
            end else begin
               status_ff <= cmd.status_code;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= idx_ff;
      if (cmd.load) begin
         page_ff     <= req_data.page_number;
         is_write_ff <= req_data.is_write;
      end
   end

   assign rsp_data.status      = status_ff;
   assign rsp_data.victim_page = victim_ff;

endmodule

// ===== rtl/core/enhanced_clock_page_replacer.sv =====
`timescale 1ns / 1ps

// Channel   Ports                          Handshake
// request   start, busy, req_data          taken when start && !busy
// result    rsp_strobe, rsp_data           one cycle per result, no backpressure
//
// One request at a time; busy is high from the cycle after acceptance
// through the cycle that carries rsp_strobe. Insert, empty or unknown
// action: status set at acceptance, then the result. Access: one slot read
// per cycle from the slot RAM over the N resident pages, plus the last compare.
// Victim: scan steps over the bit flops until a slot has both bits clear,
// then each slot behind the victim moves down (slot RAM read then write).
// Reset (synchronous) empties the store; the results cannot be stalled.

module enhanced_clock_page_replacer #(
   parameter int FRAMES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ecpr_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ecpr_pkg::rsp_type rsp_data
);

   ecpr_pkg::cmd_type cmd;
   ecpr_pkg::sts_type sts;

   ecpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_action(req_data.action),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_strobe(rsp_strobe)
   );

   ecpr_dp #(
      .FRAMES(FRAMES)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .cmd     (cmd),
      .sts     (sts),
      .rsp_data(rsp_data)
   );

endmodule

// ===== sim/enhanced_clock_page_replacer_test.sv =====
`timescale 1ns / 1ps

module enhanced_clock_page_replacer_test;

   localparam int DEPTH            = 8;
   localparam int SCAN_PASSES      = 3;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int ROWS             = 25;
   localparam int RANDOM_PER_PHASE = 545;
   localparam int MAX_GAP          = 20;
   localparam int DRAIN_CYCLES     = 64;
   localparam int DRAIN_LIMIT      = 1000;

   typedef struct packed {
      ecpr_pkg::req_type rq;
      logic              typed;
      ecpr_pkg::rsp_type want;
   } step_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   ecpr_pkg::req_type req_data;
   logic              rsp_strobe;
   ecpr_pkg::rsp_type rsp_data;

   // shadow of the resident store, oldest page at index 0
   logic [ecpr_pkg::PAGE_W-1:0] slot_page [DEPTH];
   logic                        ref_bit   [DEPTH];
   logic                        mod_bit   [DEPTH];
   int                          frames_used;

   ecpr_pkg::rsp_type page_results_due [$];
   int                bad_count = 0;
   int                send_idle_pct;
   step_row_type      plan [ROWS];

   enhanced_clock_page_replacer #(
      .FRAMES(DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // predicts each result and updates the shadow store like the block does (second-chance victim scan)
   function automatic ecpr_pkg::rsp_type next_page_result(input ecpr_pkg::req_type rq);
      ecpr_pkg::rsp_type r;
      logic              hit;
      logic              found;
      int                k;
      int                j;
      int                pass;
      r.status      = ecpr_pkg::STATUS_DONE;
      r.victim_page = '0;
      case (rq.action)
         ecpr_pkg::ACT_INSERT: begin
            if (frames_used >= DEPTH) begin
               r.status = ecpr_pkg::STATUS_FULL;
            end else begin
               slot_page[frames_used] = rq.page_number;
               ref_bit[frames_used]   = 1'b0;
               mod_bit[frames_used]   = 1'b0;
               frames_used++;
            end
         end
         ecpr_pkg::ACT_ACCESS: begin
            hit = 1'b0;
            for (k = 0; k < frames_used; k++) begin
               if (slot_page[k] == rq.page_number) begin
                  ref_bit[k] = 1'b1;
                  if (rq.is_write) mod_bit[k] = 1'b1;
                  hit = 1'b1;
               end
            end
            if (!hit) r.status = ecpr_pkg::STATUS_NOT_RESIDENT;
         end
         ecpr_pkg::ACT_VICTIM: begin
            if (frames_used == 0) begin
               r.status = ecpr_pkg::STATUS_EMPTY;
            end else begin
               found = 1'b0;
               for (pass = 0; pass < SCAN_PASSES && !found; pass++) begin
                  for (k = 0; k < frames_used && !found; k++) begin
                     if (!ref_bit[k] && !mod_bit[k]) begin
                        r.status      = ecpr_pkg::STATUS_VICTIM;
                        r.victim_page = slot_page[k];
                        for (j = k; j + 1 < frames_used; j++) begin
                           slot_page[j] = slot_page[j+1];
                           ref_bit[j]   = ref_bit[j+1];
                           mod_bit[j]   = mod_bit[j+1];
                        end
                        frames_used--;
                        found = 1'b1;
                     end else if (ref_bit[k] ^ mod_bit[k]) begin
                        ref_bit[k] = 1'b0;
                        mod_bit[k] = 1'b0;
                     end else begin
                        ref_bit[k] = 1'b0;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic step_row_type mk(input logic [1:0] act,
                                       input logic [ecpr_pkg::PAGE_W-1:0] pg,
                                       input logic wr, input logic typed,
                                       input logic [2:0] st);
      step_row_type r;
      r.rq.action        = act;
      r.rq.page_number   = pg;
      r.rq.is_write      = wr;
      r.typed            = typed;
      r.want.status      = st;
      r.want.victim_page = '0;
      return r;
   endfunction

   // accesses mostly hit resident pages, plus a small page pool, so the scan sees
   // every bit pattern; some junk actions and far pages mixed in
   function automatic ecpr_pkg::req_type random_request();
      ecpr_pkg::req_type r;
      logic [31:0]       raw;
      int                pick;
      raw           = $urandom;
      r.is_write    = raw[31];
      r.page_number = ($urandom_range(0, 1) != 0)
                      ? raw[ecpr_pkg::PAGE_W-1:0]
                      : ecpr_pkg::PAGE_W'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         r.action = ecpr_pkg::ACT_INSERT;
         if (frames_used > 0 && $urandom_range(0, 9) == 0)
            r.page_number = slot_page[$urandom_range(0, frames_used - 1)];
      end else if (pick < 70) begin
         r.action = ecpr_pkg::ACT_ACCESS;
         if (frames_used > 0 && $urandom_range(0, 9) < 8)
            r.page_number = slot_page[$urandom_range(0, frames_used - 1)];
      end else if (pick < 95) begin
         r.action = ecpr_pkg::ACT_VICTIM;
      end else begin
         r.action = ACT_UNUSED;
      end
      return r;
   endfunction

   task automatic send_request(input ecpr_pkg::req_type item, input logic typed,
                               input ecpr_pkg::rsp_type want);
      int                gap;
      ecpr_pkg::rsp_type predicted;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      // request taken at this edge
      predicted = next_page_result(item);
      page_results_due.push_back(typed ? want : predicted);
   endtask

   always @(posedge clock) begin
      ecpr_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (page_results_due.size() == 0) begin
            bad_count++;
            if (bad_count <= 10)
               $display("unexpected result: status %0d victim %h",
                        rsp_data.status, rsp_data.victim_page);
         end else begin
            want = page_results_due.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.victim_page !== want.victim_page) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("mismatch: status exp %0d got %0d, victim exp %h got %h",
                           want.status, rsp_data.status,
                           want.victim_page, rsp_data.victim_page);
            end
         end
      end
   end

   initial begin
      int i;
      int phase;
      int waited;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      frames_used = 0;
      for (i = 0; i < DEPTH; i++) begin
         slot_page[i] = '0;
         ref_bit[i]   = 1'b0;
         mod_bit[i]   = 1'b0;
      end
      send_idle_pct = 30;

      plan[0]  = mk(ecpr_pkg::ACT_VICTIM, 20'h00000, 1'b0, 1'b1, ecpr_pkg::STATUS_EMPTY);
      plan[1]  = mk(ecpr_pkg::ACT_ACCESS, 20'hFFFFF, 1'b1, 1'b1,
                    ecpr_pkg::STATUS_NOT_RESIDENT);
      plan[2]  = mk(ACT_UNUSED, 20'hFFFFF, 1'b1, 1'b1, ecpr_pkg::STATUS_DONE);
      plan[3]  = mk(ACT_UNUSED, 20'h00000, 1'b0, 1'b1, ecpr_pkg::STATUS_DONE);
      plan[4]  = mk(ecpr_pkg::ACT_INSERT, 20'h00000, 1'b0, 1'b1, ecpr_pkg::STATUS_DONE);
      plan[5]  = mk(ecpr_pkg::ACT_INSERT, 20'hFFFFF, 1'b1, 1'b1, ecpr_pkg::STATUS_DONE);
      // duplicate entry
      plan[6]  = mk(ecpr_pkg::ACT_INSERT, 20'h00000, 1'b0, 1'b1, ecpr_pkg::STATUS_DONE);
      plan[7]  = mk(ecpr_pkg::ACT_INSERT, 20'hAAAAA, 1'b0, 1'b1, ecpr_pkg::STATUS_DONE);
      plan[8]  = mk(ecpr_pkg::ACT_INSERT, 20'h55555, 1'b1, 1'b1, ecpr_pkg::STATUS_DONE);
      plan[9]  = mk(ecpr_pkg::ACT_INSERT, 20'h00001, 1'b0, 1'b1, ecpr_pkg::STATUS_DONE);
      plan[10] = mk(ecpr_pkg::ACT_INSERT, 20'h80000, 1'b0, 1'b1, ecpr_pkg::STATUS_DONE);
      plan[11] = mk(ecpr_pkg::ACT_INSERT, 20'h7FFFF, 1'b0, 1'b1, ecpr_pkg::STATUS_DONE);
      plan[12] = mk(ecpr_pkg::ACT_INSERT, 20'h12345, 1'b0, 1'b1, ecpr_pkg::STATUS_FULL);
      // hits both copies
      plan[13] = mk(ecpr_pkg::ACT_ACCESS, 20'h00000, 1'b1, 1'b0, ecpr_pkg::STATUS_DONE);
      plan[14] = mk(ecpr_pkg::ACT_ACCESS, 20'hFFFFF, 1'b0, 1'b0, ecpr_pkg::STATUS_DONE);
      plan[15] = mk(ecpr_pkg::ACT_ACCESS, 20'hAAAAA, 1'b1, 1'b0, ecpr_pkg::STATUS_DONE);
      plan[16] = mk(ecpr_pkg::ACT_ACCESS, 20'hAAAAA, 1'b0, 1'b0, ecpr_pkg::STATUS_DONE);
      plan[17] = mk(ecpr_pkg::ACT_ACCESS, 20'h12345, 1'b0, 1'b1,
                    ecpr_pkg::STATUS_NOT_RESIDENT);
      plan[18] = mk(ecpr_pkg::ACT_VICTIM, 20'h00000, 1'b0, 1'b0, ecpr_pkg::STATUS_DONE);
      plan[19] = mk(ecpr_pkg::ACT_VICTIM, 20'hFFFFF, 1'b1, 1'b0, ecpr_pkg::STATUS_DONE);
      plan[20] = mk(ecpr_pkg::ACT_VICTIM, 20'h00000, 1'b0, 1'b0, ecpr_pkg::STATUS_DONE);
      plan[21] = mk(ecpr_pkg::ACT_ACCESS, 20'h00001, 1'b1, 1'b0, ecpr_pkg::STATUS_DONE);
      plan[22] = mk(ecpr_pkg::ACT_ACCESS, 20'h80000, 1'b1, 1'b0, ecpr_pkg::STATUS_DONE);
      plan[23] = mk(ecpr_pkg::ACT_ACCESS, 20'h7FFFF, 1'b1, 1'b0, ecpr_pkg::STATUS_DONE);
      plan[24] = mk(ecpr_pkg::ACT_VICTIM, 20'h00000, 1'b0, 1'b0, ecpr_pkg::STATUS_DONE);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < ROWS; i++) send_request(plan[i].rq, plan[i].typed, plan[i].want);

      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 77 : 0;
         repeat (RANDOM_PER_PHASE) send_request(random_request(), 1'b0, '0);
      end
      start <= 1'b0;

      waited = 0;
      while (page_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (bad_count == 0 && page_results_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ecpr_pkg.sv
rtl/core/ecpr_ram.sv
rtl/core/ecpr_ctrl.sv
rtl/core/ecpr_dp.sv
rtl/core/enhanced_clock_page_replacer.sv
sim/enhanced_clock_page_replacer_test.sv
